>>> rtl/vsdp_pkg.sv
// Shared types and constants for the vertical seam finder.
package vsdp_pkg;

  // Field and register widths
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int ENERGY_W  = 16;
  localparam int COST_W    = 24;
  localparam int OUT_W     = 8;

  // Operation codes carried on the input beat
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SEAM = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  // Saturation limits of a cumulative cost
  localparam logic signed [COST_W-1:0] COST_MAX = 24'sh7FFFFF;
  localparam logic signed [COST_W-1:0] COST_MIN = 24'sh800000;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic rd_first;   // read left and middle neighbours
    logic capture;    // hold first read data, read right neighbour
    logic take_min;   // reduce the three neighbours to their minimum
    logic finish;     // write the cost or step the trace back
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic step_needed;  // a request now will need a trace step
    logic out_busy;     // result register full and not drained this cycle
  } status_t;

endpackage

>>> rtl/vertical_seam_dp_finder_top.sv
// Top level of the minimum vertical seam finder.
//
//   channel  signals                                     direction  beat
//   in       in_valid/in_ready, operation, energy        sink       load pixel or seam request
//   out      out_valid/out_ready, seam_valid, seam_row,  source     one per seam request
//            seam_col, seam_last
//   cfg      cfg_wen, cfg_index, cfg_data                sink       register write, no wait
//
// A pixel load reads the cost memory twice over its two read ports to fetch the three
// neighbours above, then reduces them to their minimum, then adds the energy and writes.
// A seam request that steps back a row runs the same steps; one that does not stays idle.
// Requests wait while the result register is full; loads do not.
// Reset is synchronous; the cost memory is not cleared and needs no clearing pass.
module vertical_seam_dp_finder_top #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [vsdp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vsdp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 operation,
  input  logic signed [vsdp_pkg::ENERGY_W-1:0] energy,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 seam_valid,
  output logic [vsdp_pkg::OUT_W-1:0]           seam_row,
  output logic [vsdp_pkg::OUT_W-1:0]           seam_col,
  output logic                                 seam_last
);

  vsdp_pkg::cmd_t    cmd;
  vsdp_pkg::status_t st;

  // Sequencer
  vsdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .st        (st),
    .cmd       (cmd)
  );

  // Memory and arithmetic
  vsdp_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .operation  (operation),
    .energy     (energy),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (out_valid),
    .seam_valid (seam_valid),
    .seam_row   (seam_row),
    .seam_col   (seam_col),
    .seam_last  (seam_last)
  );

endmodule

>>> rtl/vsdp_ctrl.sv
// Sequencer for pixel loads and seam trace steps.
module vsdp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  vsdp_pkg::status_t st,
  output vsdp_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_MIN  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  // Take a load whenever idle; take a request only when the result register frees up
  assign in_ready = (state == S_IDLE) &&
                    ((operation == vsdp_pkg::OP_LOAD) || !st.out_busy);
  assign accept   = in_valid && in_ready;

  // Decode commands from the state
  always_comb begin
    cmd.accept   = accept;
    cmd.rd_first = (state == S_RD1);
    cmd.capture  = (state == S_RD2);
    cmd.take_min = (state == S_MIN);
    cmd.finish   = (state == S_FIN);
  end

  // Advance through the read, reduce and finish steps
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (operation == vsdp_pkg::OP_LOAD || st.step_needed) begin
            state_next = S_RD1;
          end
        end
      end
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_MIN;
      S_MIN:   state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/vsdp_datapath.sv
// Cost memory, load and trace counters, neighbour minimum and result register.
module vsdp_datapath #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [vsdp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vsdp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 operation,
  input  logic signed [vsdp_pkg::ENERGY_W-1:0] energy,
  input  logic                                 out_ready,
  input  vsdp_pkg::cmd_t                       cmd,
  output vsdp_pkg::status_t                    st,
  output logic                                 out_valid,
  output logic                                 seam_valid,
  output logic [vsdp_pkg::OUT_W-1:0]           seam_row,
  output logic [vsdp_pkg::OUT_W-1:0]           seam_col,
  output logic                                 seam_last
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = vsdp_pkg::CFG_W;
  localparam int KW    = vsdp_pkg::COST_W;

  localparam logic [NW-1:0] ROWS_RST = (MAX_ROWS < 256) ? NW'(MAX_ROWS) : 9'd256;
  localparam logic [NW-1:0] COLS_RST = (MAX_COLS < 256) ? NW'(MAX_COLS) : 9'd256;
  localparam logic [10:0]   ROWS_LIM = 11'(MAX_ROWS);
  localparam logic [10:0]   COLS_LIM = 11'(MAX_COLS);

  // Cost memory: one write port, two registered read ports
  logic signed [KW-1:0] mem [DEPTH];
  logic [AW-1:0]        addr_a;
  logic [AW-1:0]        addr_b;
  logic [AW-1:0]        addr_w;
  logic                 mem_we;
  logic signed [KW-1:0] rd_a;
  logic signed [KW-1:0] rd_b;

  // Control state
  logic [NW-1:0]        rows_in_use;
  logic [NW-1:0]        cols_in_use;
  logic [NW-1:0]        load_row;
  logic [NW-1:0]        load_col;
  logic signed [KW-1:0] best_cost;
  logic [NW-1:0]        best_col;
  logic [NW-1:0]        trace_row;
  logic [NW-1:0]        trace_col;
  logic                 map_ready;
  logic                 seam_done;

  // Per-beat payload
  logic                                 op_reg;
  logic signed [vsdp_pkg::ENERGY_W-1:0] energy_reg;
  logic signed [KW-1:0]                 nb_l;
  logic signed [KW-1:0]                 nb_m;
  logic signed [KW-1:0]                 nb_r;
  logic signed [KW-1:0]                 min_cost;

  // Combinational helpers
  logic [NW-1:0]        src_row;
  logic [NW-1:0]        src_col;
  logic [NW-1:0]        up_row;
  logic [NW-1:0]        col_l;
  logic [NW:0]          col_r;
  logic [RW-1:0]        up_row_a;
  logic                 has_left;
  logic                 has_right;
  logic signed [KW-1:0] min_lm;
  logic signed [KW-1:0] min_next;
  logic signed [KW:0]   sum;
  logic signed [KW-1:0] cost_new;
  logic                 in_last_row;
  logic                 take_best;
  logic signed [KW-1:0] best_cost_next;
  logic [NW-1:0]        best_col_next;
  logic                 col_wrap;
  logic                 row_wrap;
  logic [NW-1:0]        step_col;
  logic [NW-1:0]        cfg_rows;
  logic [NW-1:0]        cfg_cols;
  logic                 cfg_hit;

  // Pick the position being worked on
  assign src_row  = (op_reg == vsdp_pkg::OP_LOAD) ? load_row : trace_row;
  assign src_col  = (op_reg == vsdp_pkg::OP_LOAD) ? load_col : trace_col;
  assign up_row   = src_row - 9'd1;
  assign up_row_a = RW'(up_row);
  assign col_l    = src_col - 9'd1;
  assign col_r    = {1'b0, src_col} + 10'd1;

  assign has_left  = (src_col != '0);
  assign has_right = (col_r < {1'b0, cols_in_use});

  // Left on port A first, then right; middle on port B
  assign addr_a = cmd.rd_first ? {up_row_a, CW'(col_l)} : {up_row_a, CW'(col_r)};
  assign addr_b = {up_row_a, CW'(src_col)};
  assign addr_w = {RW'(load_row), CW'(load_col)};
  assign mem_we = cmd.finish && (op_reg == vsdp_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_w] <= cost_new;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Reduce clipped neighbours; right neighbour arrives on port A this cycle
  always_comb begin
    min_lm = nb_m;
    if (has_left && (nb_l < nb_m)) begin
      min_lm = nb_l;
    end
    min_next = min_lm;
    if (has_right && (rd_a < min_lm)) begin
      min_next = rd_a;
    end
  end

  // Add energy and saturate to the cost range; the top row takes the energy alone
  always_comb begin
    sum = {min_cost[KW-1], min_cost} +
          {{(KW + 1 - vsdp_pkg::ENERGY_W){energy_reg[vsdp_pkg::ENERGY_W-1]}}, energy_reg};
    if (load_row == '0) begin
      cost_new = {{(KW - vsdp_pkg::ENERGY_W){energy_reg[vsdp_pkg::ENERGY_W-1]}}, energy_reg};
    end else if (sum[KW] != sum[KW-1]) begin
      cost_new = sum[KW] ? vsdp_pkg::COST_MIN : vsdp_pkg::COST_MAX;
    end else begin
      cost_new = sum[KW-1:0];
    end
  end

  // Track the first least-cost column of the last row
  assign in_last_row = (({1'b0, load_row} + 10'd1) == {1'b0, rows_in_use});
  assign take_best   = in_last_row && ((load_col == '0) || (cost_new < best_cost));
  assign best_cost_next = take_best ? cost_new : best_cost;
  assign best_col_next  = take_best ? load_col : best_col;
  assign col_wrap = (({1'b0, load_col} + 10'd1) >= {1'b0, cols_in_use});
  assign row_wrap = (({1'b0, load_row} + 10'd1) >= {1'b0, rows_in_use});

  // Step back: prefer left, then right, then straight up
  always_comb begin
    step_col = trace_col;
    if (has_left && (nb_l == min_cost)) begin
      step_col = col_l;
    end else if (has_right && (nb_r == min_cost)) begin
      step_col = col_r[NW-1:0];
    end
  end

  // Clamp configuration values
  always_comb begin
    cfg_rows = cfg_data;
    if (cfg_data == '0) begin
      cfg_rows = 9'd1;
    end else if ({2'b00, cfg_data} > ROWS_LIM) begin
      cfg_rows = NW'(MAX_ROWS);
    end
    cfg_cols = cfg_data;
    if (cfg_data < 9'd2) begin
      cfg_cols = 9'd2;
    end else if ({2'b00, cfg_data} > COLS_LIM) begin
      cfg_cols = NW'(MAX_COLS);
    end
  end

  assign cfg_hit = cfg_wen &&
                   ((cfg_index == vsdp_pkg::REG_ROWS) || (cfg_index == vsdp_pkg::REG_COLS));

  // Status back to the controller
  assign st.step_needed = map_ready && !seam_done && (trace_row != '0);
  assign st.out_busy    = out_valid && !out_ready;

  // Hold the beat payload and neighbour costs
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_reg     <= operation;
      energy_reg <= energy;
    end
    if (cmd.capture) begin
      nb_l <= rd_a;
      nb_m <= rd_b;
    end
    if (cmd.take_min) begin
      nb_r     <= rd_a;
      min_cost <= min_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.accept && (operation == vsdp_pkg::OP_SEAM)) begin
      if (!map_ready || seam_done) begin
        seam_valid <= 1'b0;
        seam_row   <= '0;
        seam_col   <= '0;
        seam_last  <= 1'b0;
      end else begin
        seam_valid <= 1'b1;
        seam_row   <= trace_row[vsdp_pkg::OUT_W-1:0];
        seam_col   <= trace_col[vsdp_pkg::OUT_W-1:0];
        seam_last  <= (trace_row == '0);
      end
    end
  end

  // Control state: configuration, accept, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RST;
      cols_in_use <= COLS_RST;
      load_row    <= '0;
      load_col    <= '0;
      best_cost   <= vsdp_pkg::COST_MAX;
      best_col    <= '0;
      trace_row   <= '0;
      trace_col   <= '0;
      map_ready   <= 1'b0;
      seam_done   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // Raise the result on a request, drop it once taken
      if (cmd.accept && (operation == vsdp_pkg::OP_SEAM)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_hit) begin
        if (cfg_index == vsdp_pkg::REG_ROWS) begin
          rows_in_use <= cfg_rows;
        end else begin
          cols_in_use <= cfg_cols;
        end
        load_row  <= '0;
        load_col  <= '0;
        best_cost <= vsdp_pkg::COST_MAX;
        best_col  <= '0;
        trace_row <= '0;
        trace_col <= '0;
        map_ready <= 1'b0;
        seam_done <= 1'b0;
      end else if (cmd.accept) begin
        if (operation == vsdp_pkg::OP_LOAD) begin
          // A load after a full map starts a new one
          if (map_ready) begin
            load_row  <= '0;
            load_col  <= '0;
            best_cost <= vsdp_pkg::COST_MAX;
            best_col  <= '0;
            trace_row <= '0;
            trace_col <= '0;
            map_ready <= 1'b0;
            seam_done <= 1'b0;
          end
        end else begin
          if (map_ready && !seam_done && (trace_row == '0)) begin
            seam_done <= 1'b1;
          end
        end
      end else if (cmd.finish) begin
        if (op_reg == vsdp_pkg::OP_LOAD) begin
          best_cost <= best_cost_next;
          best_col  <= best_col_next;
          if (col_wrap) begin
            load_col <= '0;
            if (row_wrap) begin
              load_row  <= '0;
              map_ready <= 1'b1;
              seam_done <= 1'b0;
              trace_row <= rows_in_use - 9'd1;
              trace_col <= best_col_next;
            end else begin
              load_row <= load_row + 9'd1;
            end
          end else begin
            load_col <= load_col + 9'd1;
          end
        end else begin
          trace_col <= step_col;
          trace_row <= trace_row - 9'd1;
        end
      end
    end
  end

endmodule
